>>> design/signed_integer_range_parser_unit_defines.svh
// Assertion macros used by the parser top level.
`ifndef SIGNED_INTEGER_RANGE_PARSER_UNIT_DEFINES_SVH
`define SIGNED_INTEGER_RANGE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIRP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIRP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sirp_pkg.sv
// Shared types and constants of the integer/range parser.
package sirp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_LEAD   = 4'd1,
        PH_PFX    = 4'd2,
        PH_FIRST  = 4'd3,
        PH_DIG    = 4'd4,
        PH_COLON  = 4'd5,
        PH_PFX2   = 4'd6,
        PH_FIRST2 = 4'd7,
        PH_DIG2   = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SYNTAX   = 3'd1,
        ST_DIGITS   = 3'd2,
        ST_LIMIT    = 3'd3,
        ST_REVERSED = 3'd4,
        ST_DISJOINT = 3'd5
    } status_t;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_BIN = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_LOW  = 2'd1;
    localparam logic [1:0] REG_HIGH = 2'd2;

    localparam logic [5:0] DIGITS_BIN = 6'd31;
    localparam logic [5:0] DIGITS_HEX = 6'd7;
    localparam logic [5:0] DIGITS_DEC = 6'd9;

    localparam logic signed [31:0] NUM_LIMIT_LO = -32'sd10000;
    localparam logic signed [31:0] NUM_LIMIT_HI = 32'sd10000;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UPPER_B = 8'h42;
    localparam logic [7:0] CH_LOWER_B = 8'h62;

    typedef struct packed {
        logic               range_mode;
        logic signed [31:0] low_bound;
        logic signed [31:0] high_bound;
    } cfg_t;

    typedef struct packed {
        logic               emit;
        status_t            status;
        logic signed [31:0] low_value;
        logic signed [31:0] high_value;
    } result_t;

endpackage

>>> design/sirp_regs.sv
// APB configuration registers: mode and the two bounds.
module sirp_regs
    import sirp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic               mode_reg;
    logic signed [31:0] low_reg;
    logic signed [31:0] high_reg;
    logic [1:0]         reg_idx;
    logic               wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
            low_reg  <= NUM_LIMIT_LO;
            high_reg <= NUM_LIMIT_HI;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE: mode_reg <= pwdata[0];
                REG_LOW:  low_reg  <= $signed(pwdata);
                REG_HIGH: high_reg <= $signed(pwdata);
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE: prdata = {31'd0, mode_reg};
            REG_LOW:  prdata = low_reg;
            REG_HIGH: prdata = high_reg;
            default:  prdata = 32'd0;
        endcase
    end

    assign cfg.range_mode = mode_reg;
    assign cfg.low_bound  = low_reg;
    assign cfg.high_bound = high_reg;

endmodule

>>> design/sirp_core.sv
// Parser state registers and the single-character step logic.
module sirp_core
    import sirp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] char_in,
    input  logic       restart,
    input  cfg_t       cfg,
    output result_t    res
);

    phase_t             phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [1:0]         radix_reg, radix_next;
    logic [5:0]         left_reg, left_next;
    logic signed [31:0] value_reg, value_next;
    logic signed [31:0] first_reg, first_next;

    // state as seen after an optional restart
    phase_t             ph;
    logic               neg;
    logic [1:0]         radix;
    logic [5:0]         left;
    logic signed [31:0] value;
    logic signed [31:0] first;

    logic [4:0]         dig;
    logic               blank;
    logic               second;
    logic               do_start, do_prefix, do_first, do_digit, do_finish, do_range;
    logic signed [31:0] ra, rb;
    logic signed [31:0] scaled;
    logic signed [31:0] sdig;

    // 0..15 for a hex digit character, 16 otherwise
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
        if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
        return d;
    endfunction

    function automatic logic digit_ok(input logic [4:0] d, input logic [1:0] r);
        logic ok;
        case (r)
            RADIX_BIN: ok = (d < 5'd2);
            RADIX_HEX: ok = (d < 5'd16);
            default:   ok = (d < 5'd10);
        endcase
        return ok;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (step_en) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            neg_reg   <= neg_next;
            radix_reg <= radix_next;
            left_reg  <= left_next;
            value_reg <= value_next;
            first_reg <= first_next;
        end
    end

    always_comb begin
        if (restart) begin
            ph    = PH_LEAD;
            neg   = 1'b0;
            radix = RADIX_DEC;
            left  = 6'd0;
            value = 32'sd0;
            first = 32'sd0;
        end else begin
            ph    = phase_reg;
            neg   = neg_reg;
            radix = radix_reg;
            left  = left_reg;
            value = value_reg;
            first = first_reg;
        end
    end

    assign dig   = digit_of(char_in);
    assign blank = (char_in == CH_SPACE) || (char_in == CH_TAB);

    // value kept signed: a negative number subtracts each digit
    always_comb begin
        case (radix)
            RADIX_BIN: scaled = value <<< 1;
            RADIX_HEX: scaled = value <<< 4;
            default:   scaled = (value <<< 3) + (value <<< 1);
        endcase
    end

    always_comb begin
        phase_next = ph;
        neg_next   = neg;
        radix_next = radix;
        left_next  = left;
        value_next = value;
        first_next = first;
        res.emit       = 1'b0;
        res.status     = ST_OK;
        res.low_value  = 32'sd0;
        res.high_value = 32'sd0;
        do_start  = 1'b0;
        do_prefix = 1'b0;
        do_first  = 1'b0;
        do_digit  = 1'b0;
        do_finish = 1'b0;
        do_range  = 1'b0;
        ra        = first;
        rb        = value;
        sdig      = 32'sd0;
        second    = (ph == PH_COLON) || (ph == PH_PFX2) || (ph == PH_FIRST2)
                    || (ph == PH_DIG2);

        unique case (ph)
            PH_LEAD: begin
                if (blank) begin
                    phase_next = ph;
                end else if (cfg.range_mode && char_in == CH_COLON) begin
                    first_next = cfg.low_bound;
                    phase_next = PH_COLON;
                end else begin
                    do_start = 1'b1;
                end
            end
            PH_COLON: begin
                if (blank || char_in == CH_NUL || char_in == CH_LF) begin
                    do_range = 1'b1;
                    ra = first;
                    rb = cfg.high_bound;
                end else begin
                    do_start = 1'b1;
                end
            end
            PH_PFX, PH_PFX2:     do_prefix = 1'b1;
            PH_FIRST, PH_FIRST2: do_first  = 1'b1;
            PH_DIG, PH_DIG2:     do_digit  = 1'b1;
            default:             phase_next = PH_IDLE;
        endcase

        if (do_start) begin
            value_next = 32'sd0;
            if (char_in == CH_MINUS || char_in == CH_PLUS) begin
                neg_next   = (char_in == CH_MINUS);
                phase_next = second ? PH_PFX2 : PH_PFX;
            end else begin
                neg_next  = 1'b0;
                do_prefix = 1'b1;
            end
        end

        if (do_prefix) begin
            if (char_in == CH_LOWER_B || char_in == CH_UPPER_B) begin
                radix_next = RADIX_BIN;
                left_next  = DIGITS_BIN;
                phase_next = second ? PH_FIRST2 : PH_FIRST;
            end else if (char_in == CH_DOLLAR) begin
                radix_next = RADIX_HEX;
                left_next  = DIGITS_HEX;
                phase_next = second ? PH_FIRST2 : PH_FIRST;
            end else begin
                radix_next = RADIX_DEC;
                left_next  = DIGITS_DEC;
                do_first   = 1'b1;
            end
        end

        sdig = neg_next ? (32'sd0 - $signed({28'd0, dig[3:0]}))
                        : $signed({28'd0, dig[3:0]});

        if (do_first) begin
            if (digit_ok(dig, radix_next)) begin
                value_next = sdig;
                phase_next = second ? PH_DIG2 : PH_DIG;
            end else begin
                res.emit   = 1'b1;
                res.status = ST_SYNTAX;
            end
        end

        if (do_digit) begin
            if (digit_ok(dig, radix)) begin
                if (left == 6'd0) begin
                    res.emit   = 1'b1;
                    res.status = ST_DIGITS;
                end else begin
                    value_next = scaled + sdig;
                    left_next  = left - 6'd1;
                end
            end else begin
                do_finish = 1'b1;
            end
        end

        if (do_finish) begin
            if (!cfg.range_mode) begin
                res.emit = 1'b1;
                if (value < cfg.low_bound || value > cfg.high_bound) begin
                    res.status = ST_LIMIT;
                end else begin
                    res.low_value  = value;
                    res.high_value = value;
                end
            end else if (value < NUM_LIMIT_LO || value > NUM_LIMIT_HI) begin
                res.emit   = 1'b1;
                res.status = ST_LIMIT;
            end else if (!second && char_in == CH_COLON) begin
                first_next = value;
                phase_next = PH_COLON;
            end else begin
                do_range = 1'b1;
                ra = second ? first : value;
                rb = value;
            end
        end

        if (do_range) begin
            res.emit = 1'b1;
            if (ra > rb) begin
                res.status = ST_REVERSED;
            end else if (rb < cfg.low_bound || ra > cfg.high_bound) begin
                res.status = ST_DISJOINT;
            end else begin
                res.low_value  = (ra < cfg.low_bound) ? cfg.low_bound : ra;
                res.high_value = (rb > cfg.high_bound) ? cfg.high_bound : rb;
            end
        end

        if (res.emit) begin
            phase_next = PH_IDLE;
        end
    end

endmodule

>>> design/signed_integer_range_parser_unit.sv
// Top level: input register, parser step, result register and APB configuration.
// Timing: a transferred character waits in the input register until the parse step takes it;
//   its result, if any, is registered onto m_valid; a stalled result holds the step back.
// Throughput: one character per cycle while m_ready is high.
// Reset: aresetn is synchronous, active low; it empties both registers, puts the parser
//   in idle (waiting for restart) and loads range_mode 1, bounds -10000 and 10000.
`include "signed_integer_range_parser_unit_defines.svh"
module signed_integer_range_parser_unit
    import sirp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // character stream
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_char_in,
    input  logic               s_restart,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_low_value,
    output logic signed [31:0] m_high_value
);

    cfg_t    cfg;
    result_t res;

    // input register: holds one transferred character until the step takes it
    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic       in_restart_reg;

    // result register
    logic               out_vld_reg;
    status_t            out_status_reg;
    logic signed [31:0] out_low_reg;
    logic signed [31:0] out_high_reg;

    logic fire;      // parse step takes the buffered character this cycle
    logic out_free;  // result register can load this cycle

    sirp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sirp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (fire),
        .char_in (in_char_reg),
        .restart (in_restart_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // A step only runs when the result register has room, so every
    // character can emit without a stall check of its own.
    assign out_free = !out_vld_reg || m_ready;
    assign fire     = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg    <= s_char_in;
            in_restart_reg <= s_restart;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= fire && res.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res.emit) begin
            out_status_reg <= res.status;
            out_low_reg    <= res.low_value;
            out_high_reg   <= res.high_value;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_status     = out_status_reg;
    assign m_low_value  = out_low_reg;
    assign m_high_value = out_high_reg;

    // an error result never carries a value
    `SIRP_ASSERT_NOW(a_err_zero, aclk, aresetn,
        m_valid && m_status != ST_OK, m_low_value == 32'sd0 && m_high_value == 32'sd0,
        "error result with nonzero value")

    // with sane bounds an accepted result is ordered
    `SIRP_ASSERT_NOW(a_ok_order, aclk, aresetn,
        m_valid && m_status == ST_OK && cfg.low_bound <= cfg.high_bound,
        m_low_value <= m_high_value, "accepted result out of order")

    // a pending result is never overwritten by a new step
    `SIRP_ASSERT_NOW(a_no_overrun, aclk, aresetn,
        out_vld_reg && !m_ready, !fire, "parse step while result stalled")

    // a character transferred while the output does not stall is in the input register in the cycle after its transfer
    `SIRP_ASSERT_NEXT(a_step_follows, aclk, aresetn,
        s_valid && s_ready && out_free && !(out_vld_reg && !m_ready), in_vld_reg,
        "transferred character lost")

endmodule
